[hdl/go_to_point_velocity_controller_core_assert.svh]
// assertion macros for the go-to-point controller checker
`ifndef GO_TO_POINT_VELOCITY_CONTROLLER_CORE_ASSERT_SVH
`define GO_TO_POINT_VELOCITY_CONTROLLER_CORE_ASSERT_SVH

// condition that holds at every edge outside reset
`define GTP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence in the cycle after the antecedent
`define GTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

// consequence in the cycle after reset is seen
`define GTP_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

[hdl/gtp_pkg.sv]
package gtp_pkg;

   localparam int VEC_W = 34;
   localparam int ANG_W = 20;
   localparam int ATAN_W = 17;

   localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
   localparam logic signed [15:0] ANGLE_GATE_Q12 = 16'sd1638;

   localparam logic [13:0] MAX_ADVANCE_RESET = 14'd1000;
   localparam logic [14:0] MAX_ROTATION_RESET = 15'd4096;

   typedef enum logic [1:0] {
      CSR_MAX_ADVANCE  = 2'd0,
      CSR_MAX_ROTATION = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic                    origin;
   } cordic_vec_type;

   // atan(2^-i) in q16 rad, rounded to nearest
   function automatic logic [ATAN_W-1:0] atan_q16(input int unsigned idx);
      case (idx)
         0:  return 17'd51472;
         1:  return 17'd30386;
         2:  return 17'd16055;
         3:  return 17'd8150;
         4:  return 17'd4091;
         5:  return 17'd2047;
         6:  return 17'd1024;
         7:  return 17'd512;
         8:  return 17'd256;
         9:  return 17'd128;
         10: return 17'd64;
         11: return 17'd32;
         12: return 17'd16;
         13: return 17'd8;
         14: return 17'd4;
         15: return 17'd2;
         16: return 17'd1;
         default: return '0;
      endcase
   endfunction

endpackage

[hdl/go_to_point_velocity_controller_core.sv]
// go-to-point velocity controller
// request channel: req_valid / req_stall with req_target_x and req_target_y,
// signed mm in the robot frame; a request is taken at an edge with valid high
// and stall low.
// response channel: rsp_valid / rsp_stall with rsp_advance_speed (mm/s) and
// rsp_rotation_speed (1/4096 rad/s), one response per request, in order.
// csr channel: csr_valid / csr_ready with csr_index and csr_wdata; index 0 is
// the advance cap, index 1 the rotation clamp, other indexes are dropped.
// csr_ready is always high; write only while no request is in flight.
// the pipeline is one quadrant stage, one cordic cell per step and two output
// stages (gain multiply, then limits).
// throughput is one request per cycle while rsp_stall stays low; each stage
// holds its own valid bit and only stops when the stage after it is full and stopped.
// when rsp_stall is high the response register holds, the stages behind it
// keep filling bubbles, and req_stall rises once the quadrant stage is full.
// synchronous reset empties every stage and restores the caps to 1000 and 4096.
module go_to_point_velocity_controller_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [14:0] req_target_x,
   input  logic signed [14:0] req_target_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [13:0]        rsp_advance_speed,
   output logic signed [15:0] rsp_rotation_speed,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   logic [13:0] max_advance_ff;
   logic [14:0] max_rotation_ff;

   logic signed [gtp_pkg::VEC_W-1:0] tx_q16;
   logic signed [gtp_pkg::VEC_W-1:0] ty_q16;
   gtp_pkg::cordic_vec_type pre_in;
   gtp_pkg::cordic_vec_type pre_ff;
   logic pre_valid_ff;
   logic pre_ready;

   gtp_pkg::cordic_vec_type chain_data [CORDIC_STEPS+1];
   logic chain_valid [CORDIC_STEPS+1];
   logic chain_ready [CORDIC_STEPS+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_advance_ff <= gtp_pkg::MAX_ADVANCE_RESET;
         max_rotation_ff <= gtp_pkg::MAX_ROTATION_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gtp_pkg::CSR_MAX_ADVANCE: max_advance_ff <= csr_wdata[13:0];
            gtp_pkg::CSR_MAX_ROTATION: max_rotation_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // quadrant stage: turn rear targets toward the forward axis
   always_comb begin
      tx_q16 = {{3{req_target_x[14]}}, req_target_x, 16'b0};
      ty_q16 = {{3{req_target_y[14]}}, req_target_y, 16'b0};
      pre_in.origin = (req_target_x == '0) && (req_target_y == '0);
      if (ty_q16[gtp_pkg::VEC_W-1]) begin
         if (!tx_q16[gtp_pkg::VEC_W-1]) begin
            pre_in.x = tx_q16;
            pre_in.y = -ty_q16;
            pre_in.z = gtp_pkg::HALF_PI_Q16;
         end else begin
            pre_in.x = -tx_q16;
            pre_in.y = ty_q16;
            pre_in.z = -gtp_pkg::HALF_PI_Q16;
         end
      end else begin
         pre_in.x = ty_q16;
         pre_in.y = tx_q16;
         pre_in.z = '0;
      end
   end

   assign pre_ready = !pre_valid_ff || chain_ready[0];
   assign req_stall = !pre_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (pre_ready) begin
         pre_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pre_ready && req_valid) begin
         pre_ff <= pre_in;
      end
   end

   assign chain_data[0] = pre_ff;
   assign chain_valid[0] = pre_valid_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      gtp_cordic_cell #(
         .STAGE(k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_valid  (chain_valid[k]),
         .up_ready  (chain_ready[k]),
         .up_data   (chain_data[k]),
         .down_valid(chain_valid[k+1]),
         .down_ready(chain_ready[k+1]),
         .down_data (chain_data[k+1])
      );
   end

   gtp_finish u_finish (
      .clock             (clock),
      .reset             (reset),
      .up_valid          (chain_valid[CORDIC_STEPS]),
      .up_ready          (chain_ready[CORDIC_STEPS]),
      .up_data           (chain_data[CORDIC_STEPS]),
      .max_advance_speed (max_advance_ff),
      .max_rotation_speed(max_rotation_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_advance_speed (rsp_advance_speed),
      .rsp_rotation_speed(rsp_rotation_speed)
   );

endmodule

[hdl/gtp_cordic_cell.sv]
module gtp_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  gtp_pkg::cordic_vec_type up_data,
   output logic                   down_valid,
   input  logic                   down_ready,
   output gtp_pkg::cordic_vec_type down_data
);

   localparam logic [gtp_pkg::ATAN_W-1:0] ATAN_STEP = gtp_pkg::atan_q16(STAGE);
   localparam logic signed [gtp_pkg::ANG_W-1:0] ATAN_EXT =
      $signed({{(gtp_pkg::ANG_W-gtp_pkg::ATAN_W){1'b0}}, ATAN_STEP});

   logic signed [gtp_pkg::VEC_W-1:0] cx;
   logic signed [gtp_pkg::VEC_W-1:0] cy;
   logic signed [gtp_pkg::VEC_W-1:0] dx;
   logic signed [gtp_pkg::VEC_W-1:0] dy;
   gtp_pkg::cordic_vec_type data_in;
   gtp_pkg::cordic_vec_type data_ff;
   logic valid_ff;

   always_comb begin
      cx = up_data.x;
      cy = up_data.y;
      dx = cy >>> STAGE;
      dy = cx >>> STAGE;
      data_in = up_data;
      if (!cy[gtp_pkg::VEC_W-1]) begin
         data_in.x = cx + dx;
         data_in.y = cy - dy;
         data_in.z = up_data.z + ATAN_EXT;
      end else begin
         data_in.x = cx - dx;
         data_in.y = cy + dy;
         data_in.z = up_data.z - ATAN_EXT;
      end
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data = data_ff;

endmodule

[hdl/gtp_finish.sv]
module gtp_finish (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  gtp_pkg::cordic_vec_type up_data,
   input  logic [13:0]            max_advance_speed,
   input  logic [14:0]            max_rotation_speed,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [13:0]            rsp_advance_speed,
   output logic signed [15:0]     rsp_rotation_speed
);

   localparam int PROD_W = 49;
   localparam logic [PROD_W-1:0] ROUND_Q33 = 49'd4294967296;

   // scaling stage
   logic signed [gtp_pkg::ANG_W-1:0] z_eff;
   logic signed [gtp_pkg::ANG_W-1:0] z_round;
   logic signed [gtp_pkg::ANG_W-1:0] z_shift;
   logic signed [15:0] angle;
   logic signed [17:0] angle_ext;
   logic signed [17:0] rot3;
   logic signed [17:0] rot_half;
   logic [32:0] dist_pos;
   logic [PROD_W-1:0] prod_in;
   logic signed [16:0] rot_in;
   logic gate_in;

   logic a_valid_ff;
   logic [PROD_W-1:0] prod_ff;
   logic signed [16:0] rot_ff;
   logic gate_ff;
   logic a_ready;
   logic b_ready;

   // limit stage
   logic [PROD_W-1:0] prod_round;
   logic [15:0] adv_raw;
   logic [13:0] adv_in;
   logic signed [16:0] lim;
   logic signed [16:0] neg_lim;
   logic signed [15:0] rot_out_in;

   logic rsp_valid_ff;
   logic [13:0] adv_ff;
   logic signed [15:0] rot_out_ff;

   always_comb begin
      z_eff = up_data.origin ? '0 : up_data.z;
      z_round = z_eff + 20'sd8;
      z_shift = z_round >>> 4;
      angle = z_shift[15:0];
      angle_ext = {{2{angle[15]}}, angle};
      rot3 = angle_ext + (angle_ext <<< 1) + 18'sd1;
      rot_half = rot3 >>> 1;
      rot_in = rot_half[16:0];
      gate_in = (angle > gtp_pkg::ANGLE_GATE_Q12) || (angle < -gtp_pkg::ANGLE_GATE_Q12);
      dist_pos = up_data.x[gtp_pkg::VEC_W-1] ? '0 : up_data.x[32:0];
      prod_in = PROD_W'(dist_pos) * PROD_W'(gtp_pkg::INV_GAIN_Q16);
   end

   assign b_ready = !rsp_valid_ff || !rsp_stall;
   assign a_ready = !a_valid_ff || b_ready;
   assign up_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && up_valid) begin
         prod_ff <= prod_in;
         rot_ff <= rot_in;
         gate_ff <= gate_in;
      end
   end

   always_comb begin
      prod_round = prod_ff + ROUND_Q33;
      adv_raw = prod_round[48:33];
      if (gate_ff) begin
         adv_in = '0;
      end else if (adv_raw > {2'b00, max_advance_speed}) begin
         adv_in = max_advance_speed;
      end else begin
         adv_in = adv_raw[13:0];
      end
      lim = $signed({2'b00, max_rotation_speed});
      neg_lim = -lim;
      if (rot_ff > lim) begin
         rot_out_in = lim[15:0];
      end else if (rot_ff < neg_lim) begin
         rot_out_in = neg_lim[15:0];
      end else begin
         rot_out_in = rot_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_ready) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         adv_ff <= adv_in;
         rot_out_ff <= rot_out_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_advance_speed = adv_ff;
   assign rsp_rotation_speed = rot_out_ff;

endmodule

[hdl/gtp_checker.sv]
`include "go_to_point_velocity_controller_core_assert.svh"

module gtp_port_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [13:0]        rsp_advance_speed,
   input logic signed [15:0] rsp_rotation_speed,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [1:0]         csr_index,
   input logic [15:0]        csr_wdata
);

   localparam logic signed [16:0] GATED_ROT_MAX = 17'sd2457;

   logic [13:0] max_adv_ff;
   logic [14:0] max_rot_ff;
   logic signed [16:0] rot_ext;
   logic signed [16:0] lim_ext;
   logic signed [16:0] neg_lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_adv_ff <= gtp_pkg::MAX_ADVANCE_RESET;
         max_rot_ff <= gtp_pkg::MAX_ROTATION_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gtp_pkg::CSR_MAX_ADVANCE: max_adv_ff <= csr_wdata[13:0];
            gtp_pkg::CSR_MAX_ROTATION: max_rot_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rot_ext = {rsp_rotation_speed[15], rsp_rotation_speed};
      lim_ext = $signed({2'b00, max_rot_ff});
      neg_lim = -lim_ext;
   end

   `GTP_ASSERT_AFTER_RESET(a_reset_empty, !rsp_valid, "response valid right after reset")

   `GTP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_advance_speed) && $stable(rsp_rotation_speed), "stalled response changed")

   `GTP_ASSERT_ALWAYS(a_adv_cap, !rsp_valid || (rsp_advance_speed <= max_adv_ff), "advance above cap")

   `GTP_ASSERT_ALWAYS(a_rot_clamp, !rsp_valid || (rot_ext <= lim_ext && rot_ext >= neg_lim), "rotation outside clamp")

   `GTP_ASSERT_ALWAYS(a_turn_gate, !rsp_valid || (rsp_advance_speed == 14'd0) || (rot_ext <= GATED_ROT_MAX && rot_ext >= -GATED_ROT_MAX), "advance while heading is large")

endmodule

bind go_to_point_velocity_controller_core gtp_port_checker u_gtp_checker (.*);
